FILE: rtl/assert_macros.svh
// assertion macros used by the top level to check its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define RPWG_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("rpwg assertion failed");

// condition that must never be seen at a clock edge
`define RPWG_NEVER(label, clk, rst_n, cond) \
	`RPWG_ASSERT(label, clk, rst_n, !(cond))

`endif

FILE: rtl/rpwg_pkg.sv
// types and constants for the ram patch write generator
package rpwg_pkg;

	localparam int unsigned AddrW  = 32;
	localparam int unsigned ValueW = 32;
	localparam int unsigned KindW  = 4;
	localparam int unsigned SizeW  = 3;
	localparam int unsigned BitPosW = 4;
	localparam int unsigned CountW = 3;

	// register reset values
	localparam logic [AddrW-1:0] RamSizeReset = '0;
	localparam logic [KindW-1:0] SetKindReset = 4'd1;

	// register indexes on the configuration port
	localparam logic RegRamSize = 1'b0;
	localparam logic RegSetKind = 1'b1;

	// size codes
	localparam logic [SizeW-1:0] SizeBits1  = 3'd0;
	localparam logic [SizeW-1:0] SizeBits2  = 3'd1;
	localparam logic [SizeW-1:0] SizeBits4  = 3'd2;
	localparam logic [SizeW-1:0] SizeBytes1 = 3'd3;
	localparam logic [SizeW-1:0] SizeBytes2 = 3'd4;
	localparam logic [SizeW-1:0] SizeBytes4 = 3'd5;

	localparam logic [SizeW-1:0]   FieldBitsSizes = 3'd3;
	localparam logic [BitPosW-1:0] MaxBitPos      = 4'd7;
	localparam logic [7:0]         FullMask       = 8'hff;

	// configuration register contents
	typedef struct packed {
		logic [AddrW-1:0] ram_bytes;
		logic [KindW-1:0] set_kind_code;
	} cfg_t;

	// one accepted descriptor
	typedef struct packed {
		logic               enabled_flag;
		logic               has_core_code;
		logic [KindW-1:0]   cheat_kind;
		logic [SizeW-1:0]   size_code;
		logic [BitPosW-1:0] bit_offset;
		logic [AddrW-1:0]   target_address;
		logic [ValueW-1:0]  write_value;
		logic               msb_first;
	} patch_t;

	// decoded write plan handed to the beat emitter
	typedef struct packed {
		logic [CountW-1:0] count;
		logic [AddrW-1:0]  start_addr;
		logic [ValueW-1:0] value;
		logic [7:0]        mask;
		logic              descend;
	} beat_plan_t;

endpackage

FILE: rtl/rpwg_if.sv
// valid/ready channels for descriptors and byte writes
interface rpwg_in_if;
	logic        valid;
	logic        ready;
	logic        enabled_flag;
	logic        has_core_code;
	logic [3:0]  cheat_kind;
	logic [2:0]  size_code;
	logic [3:0]  bit_offset;
	logic [31:0] target_address;
	logic [31:0] write_value;
	logic        msb_first;

	modport source (
		output valid, enabled_flag, has_core_code, cheat_kind, size_code,
		       bit_offset, target_address, write_value, msb_first,
		input  ready
	);
	modport sink (
		input  valid, enabled_flag, has_core_code, cheat_kind, size_code,
		       bit_offset, target_address, write_value, msb_first,
		output ready
	);
endinterface

interface rpwg_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] byte_address;
	logic [7:0]  byte_data;
	logic [7:0]  bit_mask;
	logic        last_write;

	modport source (
		output valid, byte_address, byte_data, bit_mask, last_write,
		input  ready
	);
	modport sink (
		input  valid, byte_address, byte_data, bit_mask, last_write,
		output ready
	);
endinterface

FILE: rtl/rpwg_cfg.sv
// apb register file holding ram size and set kind code
module rpwg_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output rpwg_pkg::cfg_t      cfg
);

	logic [rpwg_pkg::AddrW-1:0] ram_bytes_q;
	logic [rpwg_pkg::KindW-1:0] set_kind_q;
	logic                       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_bytes_q <= rpwg_pkg::RamSizeReset;
			set_kind_q  <= rpwg_pkg::SetKindReset;
		end else if (wr_en) begin
			unique case (paddr[2])
				rpwg_pkg::RegRamSize: ram_bytes_q <= pwdata;
				rpwg_pkg::RegSetKind: set_kind_q <= pwdata[rpwg_pkg::KindW-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (paddr[2])
			rpwg_pkg::RegRamSize: prdata = ram_bytes_q;
			rpwg_pkg::RegSetKind: prdata = {28'd0, set_kind_q};
			default:              prdata = '0;
		endcase
	end

	assign cfg.ram_bytes     = ram_bytes_q;
	assign cfg.set_kind_code = set_kind_q;

endmodule

FILE: rtl/rpwg_decode.sv
// checks a descriptor and turns it into a plan of byte writes
module rpwg_decode (
	input  rpwg_pkg::patch_t     patch,
	input  rpwg_pkg::cfg_t       cfg,
	output rpwg_pkg::beat_plan_t plan
);

	logic        pass;
	logic [3:0]  fmask;
	logic [10:0] data_sh;
	logic [10:0] mask_sh;
	logic        field_ok;
	logic [2:0]  nbytes;
	logic [31:0] nbytes_w;
	logic        bytes_ok;
	logic        is_field;

	// gate on ram size, enable, core code and kind
	assign pass = (cfg.ram_bytes != '0) && patch.enabled_flag && !patch.has_core_code
		&& (patch.cheat_kind == cfg.set_kind_code);

	assign is_field = patch.size_code < rpwg_pkg::FieldBitsSizes;

	// sub-byte field mask
	always_comb begin
		unique case (patch.size_code)
			rpwg_pkg::SizeBits1: fmask = 4'h1;
			rpwg_pkg::SizeBits2: fmask = 4'h3;
			rpwg_pkg::SizeBits4: fmask = 4'hf;
			default:             fmask = 4'h0;
		endcase
	end

	assign data_sh  = {7'd0, patch.write_value[3:0] & fmask} << patch.bit_offset[2:0];
	assign mask_sh  = {7'd0, fmask} << patch.bit_offset[2:0];
	assign field_ok = (patch.target_address < cfg.ram_bytes)
		&& (patch.bit_offset <= rpwg_pkg::MaxBitPos);

	// whole-byte count
	always_comb begin
		unique case (patch.size_code)
			rpwg_pkg::SizeBytes1: nbytes = 3'd1;
			rpwg_pkg::SizeBytes2: nbytes = 3'd2;
			rpwg_pkg::SizeBytes4: nbytes = 3'd4;
			default:              nbytes = 3'd0;
		endcase
	end

	assign nbytes_w = {29'd0, nbytes};
	assign bytes_ok = (nbytes != 3'd0) && (nbytes_w <= cfg.ram_bytes)
		&& (patch.target_address <= cfg.ram_bytes - nbytes_w);

	// build the plan; big endian starts at the top byte and walks down
	always_comb begin
		plan.descend = 1'b0;
		plan.mask    = rpwg_pkg::FullMask;
		plan.value   = patch.write_value;
		plan.start_addr = patch.target_address;
		plan.count   = 3'd0;
		if (is_field) begin
			plan.value = {24'd0, data_sh[7:0]};
			plan.mask  = mask_sh[7:0];
			plan.count = (pass && field_ok) ? 3'd1 : 3'd0;
		end else begin
			plan.descend = patch.msb_first;
			plan.count   = (pass && bytes_ok) ? nbytes : 3'd0;
			if (patch.msb_first) begin
				plan.start_addr = patch.target_address + nbytes_w - 32'd1;
			end
		end
	end

endmodule

FILE: rtl/rpwg_emitter.sv
// holds one write plan and sends its byte writes one beat per cycle while wr.ready is high
module rpwg_emitter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 plan_valid,
	input  rpwg_pkg::beat_plan_t plan,
	output logic                 free,
	output logic                 load,
	rpwg_out_if.source           wr
);

	logic                        valid_s2;
	logic [rpwg_pkg::CountW-1:0] remain_s2;
	logic [rpwg_pkg::AddrW-1:0]  addr_s2;
	logic [rpwg_pkg::ValueW-1:0] value_s2;
	logic [7:0]                  mask_s2;
	logic                        descend_s2;
	logic                        beat_fire;
	logic                        last;

	assign last      = remain_s2 == 3'd1;
	assign beat_fire = valid_s2 && wr.ready;
	assign free      = !valid_s2 || (beat_fire && last);
	assign load      = plan_valid && free;

	// beat count and valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			remain_s2 <= '0;
		end else if (load) begin
			valid_s2  <= 1'b1;
			remain_s2 <= plan.count;
		end else if (beat_fire) begin
			valid_s2  <= !last;
			remain_s2 <= remain_s2 - 3'd1;
		end
	end

	// beat payload, stepped after each accepted beat
	always_ff @(posedge clk) begin
		if (load) begin
			addr_s2    <= plan.start_addr;
			value_s2   <= plan.value;
			mask_s2    <= plan.mask;
			descend_s2 <= plan.descend;
		end else if (beat_fire) begin
			addr_s2  <= descend_s2 ? addr_s2 - 32'd1 : addr_s2 + 32'd1;
			value_s2 <= {8'd0, value_s2[31:8]};
		end
	end

	assign wr.valid        = valid_s2;
	assign wr.byte_address = addr_s2;
	assign wr.byte_data    = value_s2[7:0];
	assign wr.bit_mask     = mask_s2;
	assign wr.last_write   = valid_s2 && last;

endmodule

FILE: rtl/ram_patch_write_generator.sv
// top level: descriptor register, decode, byte write emitter and apb registers
//
// Usage:
//   patch: valid/ready channel of memory-patch descriptors, one per beat.
//   wr:    valid/ready channel of masked byte writes, one write per beat,
//          last_write marks the final write of a descriptor.
//   apb:   ram byte count at byte address 0, set_kind_code at byte address 4.
// Path: a descriptor is taken into the input register, decoded there
//   combinationally and loaded into the emitter register, which drives wr.
// Throughput: one byte write per cycle while wr.ready is high; a descriptor
//   that yields n writes (at most four, for a 4-byte patch) holds the emitter
//   until its last write is taken; the next descriptor is accepted and decoded
//   meanwhile. A skipped descriptor leaves the input register the next cycle.
// Reset: arst_n clears both channels to empty; the ram byte count resets to
//   zero, which skips every descriptor, and set_kind_code resets to one.
// Stall: while wr.ready is low the current write holds; one more descriptor
//   waits in the input register and then patch.ready drops.
`include "assert_macros.svh"

module ram_patch_write_generator (
	input  logic         clk,
	input  logic         arst_n,
	rpwg_in_if.sink      patch,
	rpwg_out_if.source   wr,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	rpwg_pkg::cfg_t       cfg;
	rpwg_pkg::patch_t     patch_s1;
	rpwg_pkg::beat_plan_t plan;
	logic                 valid_s1;
	logic                 in_fire;
	logic                 adv_s1;
	logic                 plan_valid;
	logic                 emit_free;
	logic                 emit_load;

	rpwg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register advances when its plan is dropped or taken
	assign plan_valid  = valid_s1 && (plan.count != 3'd0);
	assign adv_s1      = valid_s1 && (!plan_valid || emit_free);
	assign patch.ready = !valid_s1 || adv_s1;
	assign in_fire     = patch.valid && patch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// descriptor capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			patch_s1.enabled_flag   <= patch.enabled_flag;
			patch_s1.has_core_code  <= patch.has_core_code;
			patch_s1.cheat_kind     <= patch.cheat_kind;
			patch_s1.size_code      <= patch.size_code;
			patch_s1.bit_offset     <= patch.bit_offset;
			patch_s1.target_address <= patch.target_address;
			patch_s1.write_value    <= patch.write_value;
			patch_s1.msb_first      <= patch.msb_first;
		end
	end

	rpwg_decode u_decode (
		.patch (patch_s1),
		.cfg   (cfg),
		.plan  (plan)
	);

	rpwg_emitter u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.plan_valid (plan_valid),
		.plan       (plan),
		.free       (emit_free),
		.load       (emit_load),
		.wr         (wr)
	);

	// only the final beat of a sub-byte field may carry a partial mask
	`RPWG_ASSERT(a_full_mask_mid, clk, arst_n,
		wr.valid && !wr.last_write |-> wr.bit_mask == rpwg_pkg::FullMask)
	// zero ram size never produces a plan
	`RPWG_NEVER(a_zero_ram, clk, arst_n, (cfg.ram_bytes == '0) && plan_valid)
	// emitter empties after the last beat unless a new plan is loaded
	`RPWG_ASSERT(a_drain, clk, arst_n,
		wr.valid && wr.ready && wr.last_write && !emit_load |=> !wr.valid)
	// a plan is never loaded while the emitter still has beats pending
	`RPWG_NEVER(a_no_overrun, clk, arst_n,
		emit_load && wr.valid && !(wr.ready && wr.last_write))

endmodule
